[src/brsd_pkg.sv]
// ----------------------------------------------------------------------------
// brsd_pkg: broadcast ratio storm detector package
// Item and result word types, mode codes, register indexes, fixed widths.
// ----------------------------------------------------------------------------
package brsd_pkg;

  // Fixed field widths
  localparam int MODE_W     = 2;
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 16;
  localparam int PCT_W      = 7;
  localparam int ELAPSED_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_PERCENT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME_LEN = 2'd2;

  // Register reset values
  localparam logic [15:0]      WINDOW_TICKS_RST  = 16'd1000;
  localparam logic [PCT_W-1:0] ALERT_PERCENT_RST = 7'd50;
  localparam logic [LEN_W-1:0] MIN_FRAME_LEN_RST = 16'd24;

  localparam logic [PCT_W-1:0]     PERCENT_FULL = 7'd100;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 17'h1FFFF;

  // Input word
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] dest_addr;
    logic [LEN_W-1:0]  frame_length;
  } brsd_in_t;

  // Result word
  typedef struct packed {
    logic [PCT_W-1:0] broadcast_percent;
    logic             storm_alert;
    logic             window_closed;
  } brsd_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic div_step;
    logic finish;
  } brsd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic closes;
  } brsd_sts_t;

endpackage

[src/brsd_ctrl.sv]
// ----------------------------------------------------------------------------
// brsd_ctrl: storm detector controller
// Handshake control, divider sequencing and result-valid tracking.
// ----------------------------------------------------------------------------
module brsd_ctrl import brsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  brsd_sts_t sts,
  output brsd_cmd_t cmd
);

  localparam int STEP_W = $clog2(PCT_W);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;

  // Take a word only when idle and the result slot is free or draining
  assign in_ready     = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid    = out_valid_r;
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.div_step = (state_r == S_DIV);
  assign cmd.finish   = (state_r == S_FIN);

  // Next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (cmd.accept) begin
          if (sts.closes) begin
            state_nxt = S_DIV;
            cnt_nxt   = STEP_W'(PCT_W - 1);
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_FIN: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

endmodule

[src/brsd_datapath.sv]
// ----------------------------------------------------------------------------
// brsd_datapath: storm detector datapath
// Config registers, saturating frame counters, tick counter, restoring
// divider for the broadcast percentage and the result word register.
// ----------------------------------------------------------------------------
module brsd_datapath import brsd_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  brsd_in_t              in_data,
  input  brsd_cmd_t             cmd,
  output brsd_sts_t             sts,
  output brsd_out_t             out_data
);

  localparam int REM_W = COUNT_WIDTH + PCT_W;

  logic [15:0]            win_r, win_nxt;
  logic [PCT_W-1:0]       thr_r, thr_nxt;
  logic [LEN_W-1:0]       minlen_r, minlen_nxt;
  logic [COUNT_WIDTH-1:0] tot_r, tot_nxt;
  logic [COUNT_WIDTH-1:0] bc_r, bc_nxt;
  logic [PCT_W-1:0]       pct_r, pct_nxt;
  logic                   alert_r, alert_nxt;
  logic [ELAPSED_W-1:0]   elapsed_r, elapsed_nxt;
  logic                   tnz_r, tnz_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [REM_W-1:0]       dsr_r, dsr_nxt;
  logic [PCT_W-1:0]       quo_r, quo_nxt;
  brsd_out_t              out_r, out_nxt;

  logic [ELAPSED_W-1:0]   el_inc;
  logic [COUNT_WIDTH-1:0] tot_inc;
  logic [COUNT_WIDTH-1:0] bc_inc;
  logic                   is_bcast;
  logic                   is_long;
  logic [REM_W-1:0]       prod;
  logic                   ge;
  logic [PCT_W-1:0]       q_clamp;
  logic [PCT_W-1:0]       pct_new;

  // Saturating increments and item decode
  assign el_inc   = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign tot_inc  = (tot_r == {COUNT_WIDTH{1'b1}}) ? tot_r : tot_r + 1'b1;
  assign bc_inc   = (bc_r == {COUNT_WIDTH{1'b1}}) ? bc_r : bc_r + 1'b1;
  assign is_bcast = (in_data.dest_addr == {ADDR_W{1'b1}});
  assign is_long  = (in_data.frame_length >= minlen_r);

  assign sts.closes = (in_data.mode == MODE_TICK) && (el_inc > {1'b0, win_r});

  // Dividend: broadcast count times 100
  assign prod = REM_W'(bc_r) * REM_W'(PERCENT_FULL);

  // One quotient bit per step
  assign ge      = (rem_r >= dsr_r);
  assign q_clamp = (quo_r > PERCENT_FULL) ? PERCENT_FULL : quo_r;
  assign pct_new = tnz_r ? q_clamp : pct_r;

  assign out_data = out_r;

  always_comb begin
    win_nxt     = win_r;
    thr_nxt     = thr_r;
    minlen_nxt  = minlen_r;
    tot_nxt     = tot_r;
    bc_nxt      = bc_r;
    pct_nxt     = pct_r;
    alert_nxt   = alert_r;
    elapsed_nxt = elapsed_r;
    tnz_nxt     = tnz_r;
    rem_nxt     = rem_r;
    dsr_nxt     = dsr_r;
    quo_nxt     = quo_r;
    out_nxt     = out_r;

    // Register writes
    if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_TICKS:  win_nxt    = cfg_data;
        REG_ALERT_PERCENT: thr_nxt    = cfg_data[PCT_W-1:0];
        REG_MIN_FRAME_LEN: minlen_nxt = cfg_data;
        default: ;
      endcase
    end

    // Item update
    if (cmd.accept) begin
      case (in_data.mode)
        MODE_FRAME: begin
          if (is_long) begin
            tot_nxt = tot_inc;
            if (is_bcast && (bc_r < tot_inc)) begin
              bc_nxt = bc_inc;
            end
          end
        end
        MODE_TICK: begin
          if (sts.closes) begin
            tnz_nxt     = (tot_r != '0);
            rem_nxt     = prod;
            dsr_nxt     = REM_W'(tot_r) << (PCT_W - 1);
            quo_nxt     = '0;
            tot_nxt     = '0;
            bc_nxt      = '0;
            elapsed_nxt = '0;
          end else begin
            elapsed_nxt = el_inc;
          end
        end
        MODE_CLEAR: begin
          tot_nxt   = '0;
          bc_nxt    = '0;
          alert_nxt = 1'b0;
        end
        default: ;
      endcase
      out_nxt.broadcast_percent = pct_r;
      out_nxt.storm_alert       = alert_nxt;
      out_nxt.window_closed     = 1'b0;
    end

    // Divider step
    if (cmd.div_step) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r;
      end
      quo_nxt = {quo_r[PCT_W-2:0], ge};
      dsr_nxt = dsr_r >> 1;
    end

    // Window close: new percentage and alert
    if (cmd.finish) begin
      pct_nxt                   = pct_new;
      alert_nxt                 = (pct_new > thr_r);
      out_nxt.broadcast_percent = pct_new;
      out_nxt.storm_alert       = (pct_new > thr_r);
      out_nxt.window_closed     = 1'b1;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= WINDOW_TICKS_RST;
      thr_r     <= ALERT_PERCENT_RST;
      minlen_r  <= MIN_FRAME_LEN_RST;
      tot_r     <= '0;
      bc_r      <= '0;
      pct_r     <= '0;
      alert_r   <= 1'b0;
      elapsed_r <= '0;
      tnz_r     <= 1'b0;
    end else begin
      win_r     <= win_nxt;
      thr_r     <= thr_nxt;
      minlen_r  <= minlen_nxt;
      tot_r     <= tot_nxt;
      bc_r      <= bc_nxt;
      pct_r     <= pct_nxt;
      alert_r   <= alert_nxt;
      elapsed_r <= elapsed_nxt;
      tnz_r     <= tnz_nxt;
    end
  end

  // Divider and result word
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
    out_r <= out_nxt;
  end

endmodule

[src/broadcast_ratio_storm_detector_top.sv]
// ----------------------------------------------------------------------------
// broadcast_ratio_storm_detector_top: broadcast storm detector
// Counts frames and broadcast frames per tick window, computes the broadcast
// percentage at each window close and raises an alert above a threshold.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_ready   brsd_in_t (mode, addr, length)
//   out_     output     out_valid / out_ready brsd_out_t (percent, alert, closed)
//   cfg_     input      cfg_valid / cfg_ready index 2 bits, data 16 bits
//
// Frames, clears and ticks that do not close a window skip the divider.
// A window-closing tick passes through accept, 7 steps of the restoring
// divider (one quotient bit per cycle), then a finish state.
// Reset is synchronous; no clearing pass, the block is ready right after.
// A stalled result word waits in the output register; the next word is
// taken in the same cycle the result drains.
// ----------------------------------------------------------------------------
module broadcast_ratio_storm_detector_top import brsd_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  brsd_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output brsd_out_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  brsd_cmd_t cmd;
  brsd_sts_t sts;

  // Config writes are never stalled
  assign cfg_ready = 1'b1;

  brsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  brsd_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

[src/brsd_checker.sv]
// ----------------------------------------------------------------------------
// brsd_checker: port-level checks for the storm detector
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module brsd_checker import brsd_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input brsd_in_t              in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input brsd_out_t             out_data
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // A clear shows up next cycle with the alert dropped
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.mode == MODE_CLEAR) |=>
      out_valid && !out_data.storm_alert && !out_data.window_closed)
    else $error("clear did not give a clean result");

  // A frame never closes a window and answers next cycle
  a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_data.mode == MODE_FRAME) |=> out_valid && !out_data.window_closed)
    else $error("frame result missing or marked closed");

  // Percentage stays in range
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.broadcast_percent <= PERCENT_FULL)
    else $error("percentage above 100");

endmodule

bind broadcast_ratio_storm_detector_top brsd_checker u_brsd_checker (.*);

[tb/sv/broadcast_ratio_storm_detector_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// broadcast_ratio_storm_detector_top_tb: storm detector self-checking bench
// Drives frames, ticks, clears and unused-mode words through the valid/ready
// input channel. Each accepted word goes to a scoreboard that models the
// frame counters, tick window, percentage and alert, and queues the expected
// result word. Result words are compared field by field in order. The run
// steps through several register settings and idle patterns on both sides.
// ----------------------------------------------------------------------------
module broadcast_ratio_storm_detector_top_tb;
  import brsd_pkg::*;

  localparam int COUNT_W = 32;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;
  localparam int PHASE_WORDS = 220;

  // Scoreboard: tracks detector state and queues expected result words
  class storm_scoreboard;
    logic [15:0]        window_ticks;
    logic [PCT_W-1:0]   alert_pct;
    logic [LEN_W-1:0]   min_len;
    logic [COUNT_W-1:0] total_frames;
    logic [COUNT_W-1:0] bcast_frames;
    logic [PCT_W-1:0]   pct;
    logic               alert;
    logic [ELAPSED_W-1:0] elapsed;
    brsd_out_t          expected_q[$];
    int                 errors;

    function new();
      window_ticks = WINDOW_TICKS_RST;
      alert_pct    = ALERT_PERCENT_RST;
      min_len      = MIN_FRAME_LEN_RST;
      total_frames = '0;
      bcast_frames = '0;
      pct          = '0;
      alert        = 1'b0;
      elapsed      = '0;
      errors       = 0;
    endfunction

    function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WINDOW_TICKS:  window_ticks = data;
        REG_ALERT_PERCENT: alert_pct    = data[PCT_W-1:0];
        REG_MIN_FRAME_LEN: min_len      = data;
        default: ;
      endcase
    endfunction

    // Update state for one accepted word and queue its result
    function void note_input(brsd_in_t w);
      brsd_out_t         res;
      longint unsigned   ratio;
      res.window_closed = 1'b0;
      case (w.mode)
        MODE_FRAME: begin
          if (w.frame_length >= min_len) begin
            total_frames = bump(total_frames);
            if (w.dest_addr == BCAST_ADDR && bcast_frames < total_frames)
              bcast_frames = bump(bcast_frames);
          end
        end
        MODE_TICK: begin
          if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
          if (elapsed > {1'b0, window_ticks}) begin
            // empty window keeps the old percentage
            if (total_frames != '0) begin
              ratio = (longint'(bcast_frames) * 100) / longint'(total_frames);
              pct = (ratio > 100) ? PERCENT_FULL : ratio[PCT_W-1:0];
            end
            alert        = (pct > alert_pct);
            total_frames = '0;
            bcast_frames = '0;
            elapsed      = '0;
            res.window_closed = 1'b1;
          end
        end
        MODE_CLEAR: begin
          total_frames = '0;
          bcast_frames = '0;
          alert        = 1'b0;
        end
        default: ;
      endcase
      res.broadcast_percent = pct;
      res.storm_alert       = alert;
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task check_result(brsd_out_t got);
      brsd_out_t exp_word;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
      end else begin
        exp_word = expected_q.pop_front();
        if (got.broadcast_percent !== exp_word.broadcast_percent)
          report($sformatf("broadcast_percent got %0d exp %0d",
                           got.broadcast_percent, exp_word.broadcast_percent));
        if (got.storm_alert !== exp_word.storm_alert)
          report($sformatf("storm_alert got %b exp %b",
                           got.storm_alert, exp_word.storm_alert));
        if (got.window_closed !== exp_word.window_closed)
          report($sformatf("window_closed got %b exp %b",
                           got.window_closed, exp_word.window_closed));
      end
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  brsd_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  brsd_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  storm_scoreboard sb = new();

  broadcast_ratio_storm_detector_top #(
    .COUNT_WIDTH(COUNT_W)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  // Hard stop
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Send one word; valid drops only for an idle gap in front of the word
  task send_word(logic [MODE_W-1:0] mode, logic [ADDR_W-1:0] addr,
                 logic [LEN_W-1:0] len);
    brsd_in_t w;
    w.mode = mode;
    w.dest_addr = addr;
    w.frame_length = len;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(w);
  endtask

  // Stop sending and wait for every expected word
  task drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task set_config(logic [15:0] window, logic [PCT_W-1:0] alert_pct,
                  logic [LEN_W-1:0] min_len);
    write_reg(REG_WINDOW_TICKS, window);
    write_reg(REG_ALERT_PERCENT, {{(CFG_DATA_W-PCT_W){1'b0}}, alert_pct});
    write_reg(REG_MIN_FRAME_LEN, min_len);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly frames, many near the length cutoff, frequent ticks
  task run_phase(int count, int bcast_pct, logic [LEN_W-1:0] min_len);
    logic [63:0]       r64;
    logic [MODE_W-1:0] mode;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    int                pick;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) drain_results();
      r64  = {$urandom(), $urandom()};
      pick = $urandom_range(99);
      if (pick < 68)      mode = MODE_FRAME;
      else if (pick < 92) mode = MODE_TICK;
      else if (pick < 97) mode = MODE_CLEAR;
      else                mode = MODE_UNUSED;
      pick = $urandom_range(99);
      if (pick < bcast_pct) addr = BCAST_ADDR;
      else if (pick[0])     addr = r64[47:0];
      else                  addr = BCAST_ADDR ^ (48'd1 << $urandom_range(47));
      pick = $urandom_range(9);
      if (pick < 4)       len = min_len + 16'($urandom_range(4)) - 16'd2;
      else if (pick < 8)  len = r64[63:48];
      else if (pick == 8) len = '0;
      else                len = '1;
      send_word(mode, addr, len);
    end
  endtask

  // Main sequence
  initial begin
    logic [15:0]      window;
    logic [PCT_W-1:0] alert_pct;
    logic [LEN_W-1:0] min_len;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: length cutoff, broadcast match, unused mode, clear
    send_word(MODE_FRAME, BCAST_ADDR, 16'd23);
    send_word(MODE_FRAME, BCAST_ADDR, 16'd24);
    send_word(MODE_FRAME, '0, 16'hFFFF);
    send_word(MODE_UNUSED, BCAST_ADDR, 16'hFFFF);
    send_word(MODE_CLEAR, BCAST_ADDR, 16'd100);
    send_word(MODE_TICK, '0, '0);
    drain_results();

    // Zero window: every tick closes; empty window keeps the percentage
    set_config(16'd0, 7'd127, 16'd0);
    send_word(MODE_TICK, BCAST_ADDR, 16'hFFFF);
    send_word(MODE_FRAME, BCAST_ADDR, 16'd0);
    send_word(MODE_FRAME, 48'h0123_4567_89AB, 16'd0);
    send_word(MODE_TICK, '0, '0);
    drain_results();

    // Full-length cutoff, zero threshold, clear then empty window re-alerts
    set_config(16'd1, 7'd0, 16'hFFFF);
    send_word(MODE_FRAME, BCAST_ADDR, 16'hFFFE);
    send_word(MODE_FRAME, BCAST_ADDR, 16'hFFFF);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_CLEAR, '0, '0);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_TICK, '0, '0);
    send_word(MODE_UNUSED, 48'hA5A5_5A5A_0F0F, 16'h1234);
    send_word(MODE_CLEAR, 48'hFFFF_0000_FFFF, 16'hABCD);

    // Random phases over idle patterns and register settings
    for (int k = 0; k < 8; k++) begin
      drain_results();
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      window    = (k == 1) ? 16'hFFFF : (k == 5) ? 16'd0 : 16'($urandom_range(1, 6));
      alert_pct = (k == 2) ? 7'd100 : (k == 3) ? 7'd0 : (k == 6) ? 7'd127
                  : 7'($urandom_range(100));
      min_len   = (k == 4) ? 16'hFFFF : (k == 7) ? 16'd0 : 16'($urandom_range(1600));
      set_config(window, alert_pct, min_len);
      run_phase(PHASE_WORDS, $urandom_range(100), min_len);
    end

    drain_results();
    // give stray words time to show after the last window close
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
src/brsd_pkg.sv
src/brsd_ctrl.sv
src/brsd_datapath.sv
src/broadcast_ratio_storm_detector_top.sv
src/brsd_checker.sv
tb/sv/broadcast_ratio_storm_detector_top_tb.sv
